// ===== rtl/sso_pkg.sv =====
`timescale 1ns / 1ps

package sso_pkg;

   // Sizing of the observer
   localparam int MAX_STATES = 8;
   localparam int FRAC_BITS  = 16;
   localparam int DATA_W     = 32;
   localparam int IDX_W      = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
   localparam int AMEM_DEPTH = MAX_STATES * MAX_STATES;
   localparam int AMEM_AW    = (AMEM_DEPTH > 1) ? $clog2(AMEM_DEPTH) : 1;
   localparam int PROD_W     = 2 * DATA_W;
   localparam int RND_W      = PROD_W - FRAC_BITS;
   localparam int ACC_W      = RND_W + $clog2(MAX_STATES + 2) + 1;

   // Item field widths
   localparam int POS_W   = 3;
   localparam int COUNT_W = 4;

   // Stream and register port widths
   localparam int REQ_TDATA_W = 104;
   localparam int REQ_TUSER_W = 4;
   localparam int RSP_TDATA_W = 32;
   localparam int CSR_AW      = 3;
   localparam int CSR_DW      = 32;

   localparam logic [0:0]         REG_STATE_COUNT   = 1'b0;
   localparam logic [COUNT_W-1:0] STATE_COUNT_RESET = 4'd4;

   // Command codes
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_LOAD   = 1'b1;

   // Coefficient targets, coded as on the input
   typedef enum logic [1:0] {
      CS_A = 2'd0,
      CS_B = 2'd1,
      CS_C = 2'd2,
      CS_L = 2'd3
   } coef_sel_type;

   // Second multiplier operand
   typedef enum logic [1:0] {
      OB_STATE = 2'd0,
      OB_INNOV = 2'd1,
      OB_DRIVE = 2'd2
   } opb_sel_type;

   // Datapath actions on the finished sum
   typedef enum logic [2:0] {
      ACT_NONE       = 3'd0,
      ACT_INNOV      = 3'd1,
      ACT_STORE_NEXT = 3'd2,
      ACT_COPY       = 3'd3,
      ACT_STORE_EST  = 3'd4
   } act_type;

   // Sequencing of the step counter
   typedef enum logic [1:0] {
      SQ_NEXT   = 2'd0,
      SQ_LOOP_J = 2'd1,
      SQ_LOOP_I = 2'd2,
      SQ_END    = 2'd3
   } seq_type;

   localparam int UPC_W = 4;

   // One control word of the program
   typedef struct packed {
      logic              mac;
      logic              loop_j;
      coef_sel_type      coef_sel;
      opb_sel_type       opb_sel;
      act_type           act;
      seq_type           seq;
      logic [UPC_W-1:0]  target;
   } ucode_type;

   // Control from the sequencer to the store and the datapath
   typedef struct packed {
      logic              mac;
      logic              first;
      coef_sel_type      coef_sel;
      opb_sel_type       opb_sel;
      act_type           act;
      logic [IDX_W-1:0]  row_i;
      logic [IDX_W-1:0]  col_j;
   } ctrl_type;

   // Program step addresses
   localparam logic [UPC_W-1:0] ST_P_MAC   = 4'd0;
   localparam logic [UPC_W-1:0] ST_P_DR1   = 4'd1;
   localparam logic [UPC_W-1:0] ST_P_DR2   = 4'd2;
   localparam logic [UPC_W-1:0] ST_INNOV   = 4'd3;
   localparam logic [UPC_W-1:0] ST_R_MAC   = 4'd4;
   localparam logic [UPC_W-1:0] ST_R_GAIN  = 4'd5;
   localparam logic [UPC_W-1:0] ST_R_DRIVE = 4'd6;
   localparam logic [UPC_W-1:0] ST_R_DR1   = 4'd7;
   localparam logic [UPC_W-1:0] ST_R_DR2   = 4'd8;
   localparam logic [UPC_W-1:0] ST_R_STORE = 4'd9;
   localparam logic [UPC_W-1:0] ST_COPY    = 4'd10;
   localparam logic [UPC_W-1:0] ST_E_MAC   = 4'd11;
   localparam logic [UPC_W-1:0] ST_E_DR1   = 4'd12;
   localparam logic [UPC_W-1:0] ST_E_DR2   = 4'd13;
   localparam logic [UPC_W-1:0] ST_E_STORE = 4'd14;
   localparam logic [UPC_W-1:0] UPC_NONE   = 4'd0;

   // The observer program: prediction, innovation, state rows, copy, estimate
   function automatic ucode_type ucode_rom(input logic [UPC_W-1:0] upc);
      ucode_type w;
      unique case (upc)
         ST_P_MAC:   w = '{1'b1, 1'b1, CS_C, OB_STATE, ACT_NONE, SQ_LOOP_J, UPC_NONE};
         ST_P_DR1:   w = '{1'b0, 1'b0, CS_A, OB_STATE, ACT_NONE, SQ_NEXT, UPC_NONE};
         ST_P_DR2:   w = '{1'b0, 1'b0, CS_A, OB_STATE, ACT_NONE, SQ_NEXT, UPC_NONE};
         ST_INNOV:   w = '{1'b0, 1'b0, CS_A, OB_STATE, ACT_INNOV, SQ_NEXT, UPC_NONE};
         ST_R_MAC:   w = '{1'b1, 1'b1, CS_A, OB_STATE, ACT_NONE, SQ_LOOP_J, UPC_NONE};
         ST_R_GAIN:  w = '{1'b1, 1'b0, CS_L, OB_INNOV, ACT_NONE, SQ_NEXT, UPC_NONE};
         ST_R_DRIVE: w = '{1'b1, 1'b0, CS_B, OB_DRIVE, ACT_NONE, SQ_NEXT, UPC_NONE};
         ST_R_DR1:   w = '{1'b0, 1'b0, CS_A, OB_STATE, ACT_NONE, SQ_NEXT, UPC_NONE};
         ST_R_DR2:   w = '{1'b0, 1'b0, CS_A, OB_STATE, ACT_NONE, SQ_NEXT, UPC_NONE};
         ST_R_STORE: w = '{1'b0, 1'b0, CS_A, OB_STATE, ACT_STORE_NEXT, SQ_LOOP_I, ST_R_MAC};
         ST_COPY:    w = '{1'b0, 1'b0, CS_A, OB_STATE, ACT_COPY, SQ_NEXT, UPC_NONE};
         ST_E_MAC:   w = '{1'b1, 1'b1, CS_C, OB_STATE, ACT_NONE, SQ_LOOP_J, UPC_NONE};
         ST_E_DR1:   w = '{1'b0, 1'b0, CS_A, OB_STATE, ACT_NONE, SQ_NEXT, UPC_NONE};
         ST_E_DR2:   w = '{1'b0, 1'b0, CS_A, OB_STATE, ACT_NONE, SQ_NEXT, UPC_NONE};
         ST_E_STORE: w = '{1'b0, 1'b0, CS_A, OB_STATE, ACT_STORE_EST, SQ_NEXT, UPC_NONE};
         default:    w = '{1'b0, 1'b0, CS_A, OB_STATE, ACT_NONE, SQ_END, UPC_NONE};
      endcase
      return w;
   endfunction

   // Saturation limits at accumulator width
   localparam logic signed [ACC_W-1:0] SAT_HI =
      {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_LO =
      {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
   localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

   // Full product of two signed words
   function automatic logic signed [PROD_W-1:0] mul_s(input logic signed [DATA_W-1:0] a,
                                                      input logic signed [DATA_W-1:0] b);
      logic signed [PROD_W-1:0] a_x;
      logic signed [PROD_W-1:0] b_x;
      a_x = PROD_W'(a);
      b_x = PROD_W'(b);
      return a_x * b_x;
   endfunction

   // Round half up, then drop the fraction bits with floor
   function automatic logic signed [RND_W-1:0] round_prod(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] s;
      s = p + signed'(RND_HALF);
      return s[PROD_W-1:FRAC_BITS];
   endfunction

   function automatic logic sat_clips(input logic signed [ACC_W-1:0] v);
      return (v > SAT_HI) || (v < SAT_LO);
   endfunction

   function automatic logic signed [DATA_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[DATA_W-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[DATA_W-1:0];
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/steady_state_state_observer_unit.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// req       in         tvalid / tready    tdata: operands, tuser: command and flags
// rsp       out        tvalid / tready    tdata: estimate, tuser: saturated
// csr       in         psel / penable     state_count at byte address 0
//
// A load item or a held sample gives its result at the next clock edge.
// A valid sample is worked out for the n states in use on the one shared
// multiplier, whose three-stage pipeline is drained after each of the
// n + 2 sums of the program.
// Reset clears the state, the estimate and every coefficient at once.
// A new item is taken while idle and the result register is free or being read.

module steady_state_state_observer_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // row_index[2:0], column_index[5:3], coefficient_value[37:6],
   // measured_output[69:38], drive_value[101:70], zero[103:102]
   input  logic [sso_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // command[0], matrix_select[2:1], sample_valid[3]
   input  logic [sso_pkg::REQ_TUSER_W-1:0]     req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // estimated_output[31:0]
   output logic [sso_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // saturated[0]
   output logic                                rsp_tuser,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sso_pkg::CSR_AW-1:0]          csr_paddr,
   input  logic [sso_pkg::CSR_DW-1:0]          csr_pwdata,
   output logic [sso_pkg::CSR_DW-1:0]          csr_prdata,
   output logic                                csr_pready
);

   logic                                 cmd, svalid;
   sso_pkg::coef_sel_type                msel;
   logic [sso_pkg::POS_W-1:0]            row, col;
   logic signed [sso_pkg::DATA_W-1:0]    coefv, meas, drive;
   logic                                 accept, run, quick, load_en;
   logic                                 out_free, busy, done;
   logic [sso_pkg::COUNT_W-1:0]          count_ff;
   logic [sso_pkg::IDX_W-1:0]            n_last;
   sso_pkg::ctrl_type                    ctrl;
   logic signed [sso_pkg::DATA_W-1:0]    coef, est;
   logic                                 clip;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [sso_pkg::RSP_TDATA_W-1:0]      rsp_est_ff;
   logic                                 rsp_sat_ff;
   logic                                 csr_wr;

   // Item fields
   assign cmd    = req_tuser[0];
   assign msel   = sso_pkg::coef_sel_type'(req_tuser[2:1]);
   assign svalid = req_tuser[3];
   assign row    = req_tdata[2:0];
   assign col    = req_tdata[5:3];
   assign coefv  = req_tdata[37:6];
   assign meas   = req_tdata[69:38];
   assign drive  = req_tdata[101:70];

   // Input handshake
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !busy && out_free;
   assign accept     = req_tvalid && req_tready;
   assign run        = accept && (cmd == sso_pkg::CMD_SAMPLE) && svalid;
   assign quick      = accept && !run;
   assign load_en    = accept && (cmd == sso_pkg::CMD_LOAD);

   // Number of states in use, as the last index
   always_comb begin
      if (count_ff == '0) begin
         n_last = '0;
      end else if (32'(count_ff) > sso_pkg::MAX_STATES) begin
         n_last = sso_pkg::IDX_W'(sso_pkg::MAX_STATES - 1);
      end else begin
         n_last = sso_pkg::IDX_W'(count_ff - sso_pkg::COUNT_W'(1));
      end
   end

   // Register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2:2] == sso_pkg::REG_STATE_COUNT);
   assign csr_prdata = (csr_paddr[2:2] == sso_pkg::REG_STATE_COUNT)
                       ? sso_pkg::CSR_DW'(count_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= sso_pkg::STATE_COUNT_RESET;
      end else if (csr_wr) begin
         count_ff <= csr_pwdata[sso_pkg::COUNT_W-1:0];
      end
   end

   sso_sequencer u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (run),
      .out_free (out_free),
      .n_last   (n_last),
      .ctrl     (ctrl),
      .busy     (busy),
      .done     (done)
   );

   sso_coef_store u_store (
      .clock      (clock),
      .reset      (reset),
      .load_en    (load_en),
      .load_sel   (msel),
      .load_row   (row),
      .load_col   (col),
      .load_value (coefv),
      .rd_sel     (ctrl.coef_sel),
      .rd_row     (ctrl.row_i),
      .rd_col     (ctrl.col_j),
      .coef       (coef)
   );

   sso_datapath u_dp (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .start  (run),
      .n_last (n_last),
      .meas   (meas),
      .drive  (drive),
      .coef   (coef),
      .est    (est),
      .clip   (clip)
   );

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (quick || done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (quick) begin
         rsp_est_ff <= est;
         rsp_sat_ff <= 1'b0;
      end else if (done) begin
         rsp_est_ff <= est;
         rsp_sat_ff <= clip;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_est_ff;
   assign rsp_tuser  = rsp_sat_ff;

endmodule

// ===== rtl/sso_sequencer.sv =====
`timescale 1ns / 1ps

module sso_sequencer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        out_free,
   input  logic [sso_pkg::IDX_W-1:0]   n_last,
   output sso_pkg::ctrl_type           ctrl,
   output logic                        busy,
   output logic                        done
);

   logic                        busy_ff, busy_in;
   logic [sso_pkg::UPC_W-1:0]   upc_ff, upc_in;
   logic [sso_pkg::IDX_W-1:0]   i_ff, i_in;
   logic [sso_pkg::IDX_W-1:0]   j_ff, j_in;
   sso_pkg::ucode_type          uw;
   logic                        go;

   // Current control word; only the final step waits on the result register
   assign uw   = sso_pkg::ucode_rom(upc_ff);
   assign go   = busy_ff && ((uw.seq != sso_pkg::SQ_END) || out_free);
   assign done = busy_ff && (uw.seq == sso_pkg::SQ_END) && out_free;
   assign busy = busy_ff;

   // Step counter, row counter and column counter
   always_comb begin
      busy_in = busy_ff;
      upc_in  = upc_ff;
      i_in    = i_ff;
      j_in    = j_ff;
      if (start) begin
         busy_in = 1'b1;
         upc_in  = sso_pkg::ST_P_MAC;
         i_in    = '0;
         j_in    = '0;
      end else if (go) begin
         case (uw.seq)
            sso_pkg::SQ_NEXT: begin
               upc_in = upc_ff + sso_pkg::UPC_W'(1);
            end
            sso_pkg::SQ_LOOP_J: begin
               if (j_ff == n_last) begin
                  j_in   = '0;
                  upc_in = upc_ff + sso_pkg::UPC_W'(1);
               end else begin
                  j_in = j_ff + sso_pkg::IDX_W'(1);
               end
            end
            sso_pkg::SQ_LOOP_I: begin
               if (i_ff == n_last) begin
                  i_in   = '0;
                  upc_in = upc_ff + sso_pkg::UPC_W'(1);
               end else begin
                  i_in   = i_ff + sso_pkg::IDX_W'(1);
                  upc_in = uw.target;
               end
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         upc_ff  <= '0;
         i_ff    <= '0;
         j_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         upc_ff  <= upc_in;
         i_ff    <= i_in;
         j_ff    <= j_in;
      end
   end

   // Control to the coefficient store and the datapath
   always_comb begin
      ctrl.mac      = go && uw.mac;
      ctrl.first    = uw.loop_j && (j_ff == '0);
      ctrl.coef_sel = uw.coef_sel;
      ctrl.opb_sel  = uw.opb_sel;
      ctrl.act      = go ? uw.act : sso_pkg::ACT_NONE;
      ctrl.row_i    = i_ff;
      ctrl.col_j    = j_ff;
   end

endmodule

// ===== rtl/sso_coef_store.sv =====
`timescale 1ns / 1ps

module sso_coef_store (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               load_en,
   input  sso_pkg::coef_sel_type              load_sel,
   input  logic [sso_pkg::POS_W-1:0]          load_row,
   input  logic [sso_pkg::POS_W-1:0]          load_col,
   input  logic signed [sso_pkg::DATA_W-1:0]  load_value,
   input  sso_pkg::coef_sel_type              rd_sel,
   input  logic [sso_pkg::IDX_W-1:0]          rd_row,
   input  logic [sso_pkg::IDX_W-1:0]          rd_col,
   output logic signed [sso_pkg::DATA_W-1:0]  coef
);

   logic signed [sso_pkg::DATA_W-1:0] amem [sso_pkg::AMEM_DEPTH];
   logic [sso_pkg::AMEM_DEPTH-1:0]    a_vld_ff;
   logic signed [sso_pkg::DATA_W-1:0] a_rd_ff;
   logic                              a_rdv_ff;
   logic signed [sso_pkg::DATA_W-1:0] b_ff [sso_pkg::MAX_STATES];
   logic signed [sso_pkg::DATA_W-1:0] c_ff [sso_pkg::MAX_STATES];
   logic signed [sso_pkg::DATA_W-1:0] l_ff [sso_pkg::MAX_STATES];
   logic signed [sso_pkg::DATA_W-1:0] vec_rd_ff, vec_rd_in;
   sso_pkg::coef_sel_type             sel_ff;

   logic                              row_ok, col_ok;
   logic [sso_pkg::IDX_W-1:0]         wr_row, wr_col;
   logic [sso_pkg::AMEM_AW-1:0]       wr_addr, rd_addr;
   logic                              a_wr, v_wr;

   // Load decode; positions beyond the built size are dropped
   assign row_ok  = (32'(load_row) < sso_pkg::MAX_STATES);
   assign col_ok  = (32'(load_col) < sso_pkg::MAX_STATES);
   assign wr_row  = sso_pkg::IDX_W'(load_row);
   assign wr_col  = sso_pkg::IDX_W'(load_col);
   assign wr_addr = sso_pkg::AMEM_AW'(wr_row) * sso_pkg::AMEM_AW'(sso_pkg::MAX_STATES)
                    + sso_pkg::AMEM_AW'(wr_col);
   assign rd_addr = sso_pkg::AMEM_AW'(rd_row) * sso_pkg::AMEM_AW'(sso_pkg::MAX_STATES)
                    + sso_pkg::AMEM_AW'(rd_col);
   assign a_wr    = load_en && row_ok && col_ok && (load_sel == sso_pkg::CS_A);
   assign v_wr    = load_en && row_ok && (load_sel != sso_pkg::CS_A);

   // Transition matrix memory with registered read
   always_ff @(posedge clock) begin
      if (a_wr) begin
         amem[wr_addr] <= load_value;
      end
      a_rd_ff  <= amem[rd_addr];
      a_rdv_ff <= a_vld_ff[rd_addr];
   end

   // Written marks: an entry never written reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= '0;
      end else if (a_wr) begin
         a_vld_ff[wr_addr] <= 1'b1;
      end
   end

   // Input, output and gain vectors
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < sso_pkg::MAX_STATES; k++) begin
            b_ff[k] <= '0;
            c_ff[k] <= '0;
            l_ff[k] <= '0;
         end
      end else if (v_wr) begin
         case (load_sel)
            sso_pkg::CS_B: b_ff[wr_row] <= load_value;
            sso_pkg::CS_C: c_ff[wr_row] <= load_value;
            default:       l_ff[wr_row] <= load_value;
         endcase
      end
   end

   // Vector read; the output row is walked by column
   always_comb begin
      case (rd_sel)
         sso_pkg::CS_B: vec_rd_in = b_ff[rd_row];
         sso_pkg::CS_C: vec_rd_in = c_ff[rd_col];
         sso_pkg::CS_L: vec_rd_in = l_ff[rd_row];
         default:       vec_rd_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      vec_rd_ff <= vec_rd_in;
      sel_ff    <= rd_sel;
   end

   assign coef = (sel_ff == sso_pkg::CS_A) ? (a_rdv_ff ? a_rd_ff : '0) : vec_rd_ff;

endmodule

// ===== rtl/sso_datapath.sv =====
`timescale 1ns / 1ps

module sso_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  sso_pkg::ctrl_type                  ctrl,
   input  logic                               start,
   input  logic [sso_pkg::IDX_W-1:0]          n_last,
   input  logic signed [sso_pkg::DATA_W-1:0]  meas,
   input  logic signed [sso_pkg::DATA_W-1:0]  drive,
   input  logic signed [sso_pkg::DATA_W-1:0]  coef,
   output logic signed [sso_pkg::DATA_W-1:0]  est,
   output logic                               clip
);

   logic signed [sso_pkg::DATA_W-1:0] meas_ff, drive_ff, innov_ff;
   logic signed [sso_pkg::DATA_W-1:0] x_ff  [sso_pkg::MAX_STATES];
   logic signed [sso_pkg::DATA_W-1:0] nx_ff [sso_pkg::MAX_STATES];
   logic signed [sso_pkg::DATA_W-1:0] opb_ff, opb_in;
   logic signed [sso_pkg::PROD_W-1:0] prod_ff;
   logic signed [sso_pkg::RND_W-1:0]  rnd;
   logic signed [sso_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic signed [sso_pkg::ACC_W-1:0]  diff;
   logic signed [sso_pkg::DATA_W-1:0] sum_sat;
   logic                              sum_clip;
   logic                              m0_ff, f0_ff, m1_ff, f1_ff;
   logic signed [sso_pkg::DATA_W-1:0] est_ff;
   logic                              clip_ff;

   // Second operand, registered alongside the coefficient read
   always_comb begin
      case (ctrl.opb_sel)
         sso_pkg::OB_STATE: opb_in = x_ff[ctrl.col_j];
         sso_pkg::OB_INNOV: opb_in = innov_ff;
         sso_pkg::OB_DRIVE: opb_in = drive_ff;
         default:           opb_in = '0;
      endcase
   end

   // Rounded product into the running sum
   assign rnd    = sso_pkg::round_prod(prod_ff);
   assign acc_in = f1_ff ? sso_pkg::ACC_W'(rnd) : acc_ff + sso_pkg::ACC_W'(rnd);

   // Saturated finished sum, and the innovation from the prediction
   assign sum_sat  = sso_pkg::sat_acc(acc_ff);
   assign sum_clip = sso_pkg::sat_clips(acc_ff);
   assign diff     = sso_pkg::ACC_W'(meas_ff) - sso_pkg::ACC_W'(sum_sat);

   // Issue flags through the multiply pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         m0_ff <= 1'b0;
         m1_ff <= 1'b0;
      end else begin
         m0_ff <= ctrl.mac;
         m1_ff <= m0_ff;
      end
   end

   // Operand, product and accumulator stages
   always_ff @(posedge clock) begin
      f0_ff   <= ctrl.first;
      f1_ff   <= f0_ff;
      opb_ff  <= opb_in;
      prod_ff <= sso_pkg::mul_s(coef, opb_ff);
      if (m1_ff) begin
         acc_ff <= acc_in;
      end
      if (start) begin
         meas_ff  <= meas;
         drive_ff <= drive;
      end
      if (ctrl.act == sso_pkg::ACT_INNOV) begin
         innov_ff <= sso_pkg::sat_acc(diff);
      end
      if (ctrl.act == sso_pkg::ACT_STORE_NEXT) begin
         nx_ff[ctrl.row_i] <= sum_sat;
      end
   end

   // Observer state, estimate and clip flag
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < sso_pkg::MAX_STATES; k++) begin
            x_ff[k] <= '0;
         end
         est_ff  <= '0;
         clip_ff <= 1'b0;
      end else begin
         if (start) begin
            clip_ff <= 1'b0;
         end
         case (ctrl.act)
            sso_pkg::ACT_STORE_NEXT: begin
               if (sum_clip) begin
                  clip_ff <= 1'b1;
               end
            end
            sso_pkg::ACT_COPY: begin
               for (int k = 0; k < sso_pkg::MAX_STATES; k++) begin
                  if (sso_pkg::IDX_W'(k) <= n_last) begin
                     x_ff[k] <= nx_ff[k];
                  end
               end
            end
            sso_pkg::ACT_STORE_EST: begin
               est_ff <= sum_sat;
               if (sum_clip) begin
                  clip_ff <= 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign est  = est_ff;
   assign clip = clip_ff;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   // One command of the observer, with every field at its bus width
   typedef struct {
      logic                             cmd;
      sso_pkg::coef_sel_type            sel;
      logic [sso_pkg::POS_W-1:0]        row;
      logic [sso_pkg::POS_W-1:0]        col;
      logic signed [sso_pkg::DATA_W-1:0] coef;
      logic signed [sso_pkg::DATA_W-1:0] meas;
      logic signed [sso_pkg::DATA_W-1:0] drive;
      logic                             valid;
   } obs_cmd_type;

   // One estimate as the block should return it
   typedef struct {
      logic [sso_pkg::DATA_W-1:0] estimate;
      logic                       saturated;
   } obs_estimate_type;

   localparam longint S32_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam longint S32_MIN = -64'sh0000_0000_8000_0000;
   localparam logic [sso_pkg::CSR_AW-1:0] STATE_COUNT_ADDR =
      sso_pkg::CSR_AW'(4 * sso_pkg::REG_STATE_COUNT);

   // Run shaping: receiver hold-off, a stretch without gaps, and the watchdog
   localparam int HOLD_AT     = 200;
   localparam int HOLD_LEN    = 400;
   localparam int CALM_FROM   = 500;
   localparam int CALM_TO     = 650;
   localparam int PHASE_ITEMS = 120;
   localparam int STALL_LIMIT = 3000;

   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            req_tvalid  = 1'b0;
   logic                            req_tready;
   logic [sso_pkg::REQ_TDATA_W-1:0] req_tdata   = '0;
   logic [sso_pkg::REQ_TUSER_W-1:0] req_tuser   = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready  = 1'b0;
   logic [sso_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                            rsp_tuser;
   logic                            csr_psel    = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite  = 1'b0;
   logic [sso_pkg::CSR_AW-1:0]      csr_paddr   = '0;
   logic [sso_pkg::CSR_DW-1:0]      csr_pwdata  = '0;
   logic [sso_pkg::CSR_DW-1:0]      csr_prdata;
   logic                            csr_pready;

   obs_cmd_type      command_backlog[$];
   obs_estimate_type awaited_estimates[$];
   obs_cmd_type      in_flight;
   int               commands_sent = 0;
   int               estimates_seen = 0;
   int               hold_left = 0;
   int               quiet_cycles = 0;
   int               fail_count = 0;

   // Observer copy: coefficients, state, estimate and the state count in use
   int          a_coef[sso_pkg::MAX_STATES][sso_pkg::MAX_STATES];
   int          b_coef[sso_pkg::MAX_STATES];
   int          c_coef[sso_pkg::MAX_STATES];
   int          l_gain[sso_pkg::MAX_STATES];
   int          x_state[sso_pkg::MAX_STATES];
   int          est_reg;
   logic [sso_pkg::COUNT_W-1:0] state_count_cfg;

   steady_state_state_observer_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   // Exact product, then round half up to the fraction width.
   function automatic longint fx_mul(input int a, input int b);
      longint p;
      p = longint'(a) * longint'(b) + (longint'(1) <<< (sso_pkg::FRAC_BITS - 1));
      return p >>> sso_pkg::FRAC_BITS;
   endfunction

   function automatic logic clips32(input longint v);
      return (v > S32_MAX) || (v < S32_MIN);
   endfunction

   function automatic int sat32(input longint v);
      if (v > S32_MAX) begin
         return 32'sh7FFF_FFFF;
      end else if (v < S32_MIN) begin
         return 32'sh8000_0000;
      end
      return int'(v);
   endfunction

   // Counts above the built size are clamped to it; a count of zero uses one state.
   function automatic int states_in_use(input logic [sso_pkg::COUNT_W-1:0] count);
      if (count == 0) begin
         return 1;
      end else if (count > sso_pkg::MAX_STATES) begin
         return sso_pkg::MAX_STATES;
      end
      return int'(count);
   endfunction

   // Applies one command to the observer copy and gives the estimate it returns.
   function automatic obs_estimate_type advance_observer(input obs_cmd_type it);
      obs_estimate_type r;
      int               n;
      longint           acc;
      int               innov;
      int               x_next[sso_pkg::MAX_STATES];
      logic             clip;
      clip = 1'b0;
      if (it.cmd == sso_pkg::CMD_LOAD) begin
         case (it.sel)
            sso_pkg::CS_A: a_coef[it.row][it.col] = it.coef;
            sso_pkg::CS_B: b_coef[it.row] = it.coef;
            sso_pkg::CS_C: c_coef[it.row] = it.coef;
            default:       l_gain[it.row] = it.coef;
         endcase
      end else if (it.valid) begin
         n = states_in_use(state_count_cfg);
         // Innovation from the old state; its clipping is not reported.
         acc = 0;
         for (int j = 0; j < n; j++) acc += fx_mul(c_coef[j], x_state[j]);
         innov = sat32(longint'(it.meas) - longint'(sat32(acc)));
         for (int i = 0; i < n; i++) begin
            acc = 0;
            for (int j = 0; j < n; j++) acc += fx_mul(a_coef[i][j], x_state[j]);
            acc += fx_mul(l_gain[i], innov);
            acc += fx_mul(b_coef[i], it.drive);
            clip |= clips32(acc);
            x_next[i] = sat32(acc);
         end
         for (int i = 0; i < n; i++) x_state[i] = x_next[i];
         // Estimate from the new state.
         acc = 0;
         for (int j = 0; j < n; j++) acc += fx_mul(c_coef[j], x_state[j]);
         clip |= clips32(acc);
         est_reg = sat32(acc);
      end
      r.estimate  = est_reg;
      r.saturated = clip;
      return r;
   endfunction

   // Input driver: offers queued commands, with random gaps outside the calm stretch.
   always @(posedge clock) begin : command_drive
      logic gap;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            awaited_estimates.push_back(advance_observer(in_flight));
            commands_sent++;
         end
         if (!req_tvalid || req_tready) begin
            gap = !(commands_sent >= CALM_FROM && commands_sent < CALM_TO) &&
                  ($urandom_range(0, 99) < 7);
            if (command_backlog.size() != 0 && !gap) begin
               in_flight = command_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {2'b00, in_flight.drive, in_flight.meas, in_flight.coef,
                              in_flight.col, in_flight.row};
               req_tuser  <= {in_flight.valid, in_flight.sel, in_flight.cmd};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks each item against the oldest awaited estimate.
   always @(posedge clock) begin : estimate_check
      obs_estimate_type want;
      if (reset) begin
         rsp_tready     <= 1'b0;
         hold_left      = 0;
         estimates_seen = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            estimates_seen++;
            if (awaited_estimates.size() == 0) begin
               $error("unexpected item: estimated_output %h, saturated %b",
                      rsp_tdata, rsp_tuser);
               fail_count++;
            end else begin
               want = awaited_estimates.pop_front();
               if (rsp_tdata !== want.estimate) begin
                  $error("estimated_output: expected %h, got %h", want.estimate, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tuser !== want.saturated) begin
                  $error("saturated: expected %b, got %b", want.saturated, rsp_tuser);
                  fail_count++;
               end
            end
            if (estimates_seen == HOLD_AT) hold_left = HOLD_LEN;
         end
         // A long hold-off once, so the block backs up onto its input.
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= (estimates_seen >= CALM_FROM && estimates_seen < CALM_TO) ||
                          ($urandom_range(0, 99) >= 7);
         end
      end
   end

   // Watchdog on cycles in which no channel moves anything.
   always @(posedge clock) begin : progress_watch
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Register access: setup cycle, then access until pready.
   task automatic csr_access(input logic wr, input logic [sso_pkg::CSR_DW-1:0] wdata,
                             output logic [sso_pkg::CSR_DW-1:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= STATE_COUNT_ADDR;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      if (wr) state_count_cfg = wdata[sso_pkg::COUNT_W-1:0];
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic check_state_count();
      logic [sso_pkg::CSR_DW-1:0] rd;
      csr_access(1'b0, '0, rd);
      if (rd !== sso_pkg::CSR_DW'(state_count_cfg)) begin
         $error("state_count: expected %h, got %h", sso_pkg::CSR_DW'(state_count_cfg), rd);
         fail_count++;
      end
   endtask

   // The bits above the count field carry random noise.
   task automatic set_state_count(input logic [sso_pkg::COUNT_W-1:0] count);
      logic [sso_pkg::CSR_DW-1:0] rd;
      csr_access(1'b1, sso_pkg::CSR_DW'(count) | ($urandom & 32'hFFFF_FFF0), rd);
      check_state_count();
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (command_backlog.size() != 0 || req_tvalid || awaited_estimates.size() != 0);
   endtask

   // Loads carry random sample fields, samples random load fields.
   task automatic queue_load(input sso_pkg::coef_sel_type sel, input int row, input int col,
                             input logic signed [sso_pkg::DATA_W-1:0] value);
      obs_cmd_type it;
      it.cmd   = sso_pkg::CMD_LOAD;
      it.sel   = sel;
      it.row   = sso_pkg::POS_W'(row);
      it.col   = sso_pkg::POS_W'(col);
      it.coef  = value;
      it.meas  = $urandom;
      it.drive = $urandom;
      it.valid = 1'($urandom_range(0, 1));
      command_backlog.push_back(it);
   endtask

   task automatic queue_sample(input logic valid,
                               input logic signed [sso_pkg::DATA_W-1:0] meas,
                               input logic signed [sso_pkg::DATA_W-1:0] drive);
      obs_cmd_type it;
      it.cmd   = sso_pkg::CMD_SAMPLE;
      it.sel   = sso_pkg::coef_sel_type'($urandom_range(0, 3));
      it.row   = sso_pkg::POS_W'($urandom_range(0, 7));
      it.col   = sso_pkg::POS_W'($urandom_range(0, 7));
      it.coef  = $urandom;
      it.meas  = meas;
      it.drive = drive;
      it.valid = valid;
      command_backlog.push_back(it);
   endtask

   // Signal values around +/-16.0, now and then anything at all.
   function automatic logic signed [sso_pkg::DATA_W-1:0] signal_value();
      if ($urandom_range(0, 9) == 0) return $urandom;
      return int'($urandom_range(0, 32'h20_0000)) - 32'sh10_0000;
   endfunction

   // Coefficients around +/-0.25 keep the loop mostly bounded; some are wild.
   function automatic logic signed [sso_pkg::DATA_W-1:0] coef_value();
      if ($urandom_range(0, 9) == 0) return $urandom;
      return int'($urandom_range(0, 32'h8000)) - 32'sh4000;
   endfunction

   // A running observer: mostly samples and coefficient updates, some noise.
   task automatic queue_random_phase(input int count, input int n_use);
      int                    pick;
      int                    lim;
      sso_pkg::coef_sel_type sel;
      obs_cmd_type           it;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         lim  = ($urandom_range(0, 4) == 0) ? sso_pkg::MAX_STATES : n_use;
         sel  = sso_pkg::coef_sel_type'($urandom_range(0, 3));
         if (pick < 50) begin
            queue_sample(1'b1, signal_value(), signal_value());
         end else if (pick < 60) begin
            queue_sample(1'b0, $urandom, $urandom);
         end else if (pick < 88) begin
            queue_load(sel, $urandom_range(0, lim - 1), $urandom_range(0, lim - 1),
                       coef_value());
         end else begin
            it.cmd   = 1'($urandom_range(0, 1));
            it.sel   = sel;
            it.row   = sso_pkg::POS_W'($urandom_range(0, 7));
            it.col   = sso_pkg::POS_W'($urandom_range(0, 7));
            it.coef  = $urandom;
            it.meas  = $urandom;
            it.drive = $urandom;
            it.valid = 1'($urandom_range(0, 1));
            command_backlog.push_back(it);
         end
      end
   endtask

   initial begin : stimulus
      logic [sso_pkg::COUNT_W-1:0] count_plan[8];
      count_plan = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd5, 4'd2, 4'd8, 4'd3};
      for (int i = 0; i < sso_pkg::MAX_STATES; i++) begin
         for (int j = 0; j < sso_pkg::MAX_STATES; j++) a_coef[i][j] = 0;
         b_coef[i]  = 0;
         c_coef[i]  = 0;
         l_gain[i]  = 0;
         x_state[i] = 0;
      end
      est_reg         = 0;
      state_count_cfg = sso_pkg::STATE_COUNT_RESET;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      check_state_count();
      @(negedge clock);

      // Directed part at the reset state count: holds, extremes, rounding.
      queue_sample(1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000);
      queue_sample(1'b1, 0, 0);
      queue_load(sso_pkg::CS_A, 7, 7, 32'sh8000_0000);
      queue_load(sso_pkg::CS_A, 0, 0, 32'sh0001_0000);
      queue_load(sso_pkg::CS_B, 0, 7, 32'sh7FFF_FFFF);
      queue_load(sso_pkg::CS_C, 0, 0, 32'sh0001_0000);
      queue_load(sso_pkg::CS_L, 3, 0, 32'sh8000_0000);
      queue_sample(1'b1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      queue_sample(1'b1, 32'sh8000_0000, 32'sh8000_0000);
      queue_sample(1'b0, 0, 0);
      queue_load(sso_pkg::CS_B, 0, 0, 32'sh0000_0001);
      queue_load(sso_pkg::CS_A, 0, 0, 0);
      queue_load(sso_pkg::CS_L, 3, 0, 0);
      // Products of exactly plus and minus one half round up.
      queue_sample(1'b1, 0, 32'sh0000_8000);
      queue_sample(1'b1, 0, 32'shFFFF_8000);
      // A row outside the states in use is stored but never read.
      queue_load(sso_pkg::CS_C, 7, 3, 32'sh7FFF_FFFF);
      queue_load(sso_pkg::CS_L, 0, 5, 32'sh0000_8000);
      queue_load(sso_pkg::CS_B, 0, 0, 32'sh0001_0000);
      queue_sample(1'b1, 32'sh0010_0000, 32'sh7FF0_0000);
      // Large state against the lowest measurement clips the innovation.
      queue_sample(1'b1, 32'sh8000_0000, 0);
      queue_sample(1'b1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      wait_drained();

      // Random phases, each under its own state count.
      foreach (count_plan[p]) begin
         set_state_count(count_plan[p]);
         @(negedge clock);
         queue_random_phase(PHASE_ITEMS, states_in_use(count_plan[p]));
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/sso_pkg.sv
rtl/sso_sequencer.sv
rtl/sso_coef_store.sv
rtl/sso_datapath.sv
rtl/steady_state_state_observer_unit.sv
tb/sv/testbench.sv
